// ===== src/mprr_pkg.sv =====
// shared constants, beat types and a helper function of the mesh packet receive router
package mprr_pkg;

    // packet layout
    localparam int PACKET_BYTES  = 32;
    localparam int PAYLOAD_BYTES = 24;
    localparam int HDR_BYTES     = 7;
    localparam int ROUTED_NODES  = 24;
    localparam int TABLE_DEPTH   = 256;

    localparam int POS_W  = $clog2(PACKET_BYTES);
    localparam int HIDX_W = $clog2(HDR_BYTES);
    localparam int K_W    = $clog2(PAYLOAD_BYTES);
    localparam int NODE_W = K_W + 1;
    localparam int TBL_AW = $clog2(TABLE_DEPTH);

    // header byte positions
    localparam logic [HIDX_W-1:0] HDR_DEST  = HIDX_W'(0);
    localparam logic [HIDX_W-1:0] HDR_GW    = HIDX_W'(1);
    localparam logic [HIDX_W-1:0] HDR_SRC   = HIDX_W'(2);
    localparam logic [HIDX_W-1:0] HDR_TTL   = HIDX_W'(3);
    localparam logic [HIDX_W-1:0] HDR_TYPE  = HIDX_W'(4);
    localparam logic [HIDX_W-1:0] HDR_FLAGS = HIDX_W'(5);
    localparam logic [HIDX_W-1:0] HDR_IDENT = HIDX_W'(6);

    // flag bits of the header flags byte
    localparam int FLAG_ACK_REQ = 0;
    localparam int FLAG_LAST    = 1;

    // verdict codes
    localparam logic [2:0] VERDICT_ADVERT   = 3'd0;
    localparam logic [2:0] VERDICT_ACCEPTED = 3'd1;
    localparam logic [2:0] VERDICT_RELAY    = 3'd2;
    localparam logic [2:0] VERDICT_WRONG_GW = 3'd3;
    localparam logic [2:0] VERDICT_CKS_BAD  = 3'd4;
    localparam logic [2:0] VERDICT_TTL_ZERO = 3'd5;
    localparam logic [2:0] VERDICT_ACK      = 3'd6;
    localparam logic [2:0] VERDICT_UNKNOWN  = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_ADDRESS    = 2'd0;
    localparam logic [1:0] CFG_DATA_TYPE_CODE = 2'd1;
    localparam logic [1:0] CFG_ADV_TYPE_CODE  = 2'd2;
    localparam logic [1:0] CFG_ACK_TYPE_CODE  = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_start;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] verdict;
        logic [7:0] source_node;
        logic [7:0] dest_node;
        logic [7:0] hop_limit;
        logic [7:0] packet_ident;
        logic       ack_required;
        logic       last_in_stream;
        logic [7:0] computed_sum;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] own_address;
        logic [7:0] data_type_code;
        logic [7:0] advert_type_code;
        logic [7:0] ack_type_code;
    } t_cfg;

    // strobes from the receive core to the routing tables
    typedef struct packed {
        logic           pay_adv;    // payload beat of an advert taken this cycle
        logic           first_pay;  // it is the first payload byte
        logic [K_W-1:0] pay_idx;    // payload byte index
        logic           byte_nz;    // payload byte is nonzero
        logic           cnt_inc;    // checksum beat of an advert taken this cycle
        logic [7:0]     src;        // source address of the current packet
    } t_tbl_ctl;

    // number of set bits in a byte
    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int b = 0; b < 8; b++) begin
            c = c + 4'(v[b]);
        end
        return c;
    endfunction

endpackage

// ===== src/mesh_packet_receive_router.sv =====
// Mesh packet receive router: takes one packet byte per beat and gives one verdict beat per
// 32-byte packet (7 header bytes, 24 payload bytes, checksum). A byte is accepted every cycle
// while the result register can drain; a result is set by the input register and the result
// register around one pass of logic after its checksum byte is accepted. Adverts update the
// next-hop and advert count tables, node updates through a pending register. Only the count
// table starts cleared after reset, by its valid bits with no clearing sweep. packet_start
// resyncs to byte zero, and a packet may also follow the checksum byte directly.
// Configuration writes take effect at once and are meant for idle periods only.
module mesh_packet_receive_router
    import mprr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata
);

    t_cfg     r_cfg;
    t_tbl_ctl tbl_ctl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address      <= 8'd1;
            r_cfg.data_type_code   <= 8'd0;
            r_cfg.advert_type_code <= 8'd1;
            r_cfg.ack_type_code    <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OWN_ADDRESS:    r_cfg.own_address      <= i_cfg_wdata;
                CFG_DATA_TYPE_CODE: r_cfg.data_type_code   <= i_cfg_wdata;
                CFG_ADV_TYPE_CODE:  r_cfg.advert_type_code <= i_cfg_wdata;
                CFG_ACK_TYPE_CODE:  r_cfg.ack_type_code    <= i_cfg_wdata;
            endcase
        end
    end

    mprr_rx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_tbl_ctl   (tbl_ctl)
    );

    mprr_route_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_own_address (r_cfg.own_address),
        .i_ctl         (tbl_ctl)
    );

endmodule

// ===== src/mprr_rx_core.sv =====
// receive core: input register, byte position, header capture, checksum sum, verdict register
module mprr_rx_core
    import mprr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    output t_tbl_ctl  o_tbl_ctl
);

    logic             r_in_valid;
    t_in_beat         r_in;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_hdr [HDR_BYTES];
    logic [7:0]       r_sum;
    logic             r_out_valid;
    t_out_beat        r_out;

    logic [POS_W-1:0] cur_pos;
    logic             is_hdr;
    logic             is_pay;
    logic             is_cks;
    logic             is_adv;
    logic             advance;
    logic [7:0]       sum_next;
    logic [2:0]       verdict;
    t_out_beat        n_out;

    // position of the held beat, resynced by packet start
    assign cur_pos = r_in.packet_start ? '0 : r_pos;
    assign is_hdr  = cur_pos < POS_W'(HDR_BYTES);
    assign is_pay  = !is_hdr && (cur_pos < POS_W'(HDR_BYTES + PAYLOAD_BYTES));
    assign is_cks  = cur_pos == POS_W'(PACKET_BYTES - 1);
    assign is_adv  = r_hdr[HDR_TYPE] == i_cfg.advert_type_code;

    // only the checksum beat needs room in the result register
    assign advance    = r_in_valid && (!is_cks || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign sum_next = r_sum + 8'(popcount8(r_in.rx_byte));

    // verdict, advert code first, then data, then ack
    always_comb begin
        priority if (is_adv) begin
            verdict = VERDICT_ADVERT;
        end else if (r_hdr[HDR_TYPE] == i_cfg.data_type_code) begin
            priority if (r_hdr[HDR_DEST] == i_cfg.own_address) begin
                verdict = (r_in.rx_byte == r_sum) ? VERDICT_ACCEPTED : VERDICT_CKS_BAD;
            end else if (r_hdr[HDR_GW] == i_cfg.own_address) begin
                verdict = (r_hdr[HDR_TTL] == 8'd0) ? VERDICT_TTL_ZERO : VERDICT_RELAY;
            end else begin
                verdict = VERDICT_WRONG_GW;
            end
        end else if (r_hdr[HDR_TYPE] == i_cfg.ack_type_code) begin
            verdict = VERDICT_ACK;
        end else begin
            verdict = VERDICT_UNKNOWN;
        end
    end

    // result beat
    always_comb begin
        n_out.verdict        = verdict;
        n_out.source_node    = r_hdr[HDR_SRC];
        n_out.dest_node      = r_hdr[HDR_DEST];
        n_out.hop_limit      = r_hdr[HDR_TTL];
        n_out.packet_ident   = r_hdr[HDR_IDENT];
        n_out.ack_required   = r_hdr[HDR_FLAGS][FLAG_ACK_REQ];
        n_out.last_in_stream = r_hdr[HDR_FLAGS][FLAG_LAST];
        n_out.computed_sum   = r_sum;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_pos <= is_cks ? '0 : cur_pos + POS_W'(1);
                if (cur_pos == '0) begin
                    r_sum <= '0;
                end else if (is_pay) begin
                    r_sum <= sum_next;
                end
            end
            if (advance && is_cks) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance && is_hdr) begin
            r_hdr[cur_pos[HIDX_W-1:0]] <= r_in.rx_byte;
        end
        if (advance && is_cks) begin
            r_out <= n_out;
        end
    end

    // table strobes
    always_comb begin
        o_tbl_ctl.pay_adv   = advance && is_pay && is_adv;
        o_tbl_ctl.pay_idx   = K_W'(cur_pos - POS_W'(HDR_BYTES));
        o_tbl_ctl.first_pay = cur_pos == POS_W'(HDR_BYTES);
        o_tbl_ctl.byte_nz   = |r_in.rx_byte;
        o_tbl_ctl.cnt_inc   = advance && is_cks && is_adv;
        o_tbl_ctl.src       = r_hdr[HDR_SRC];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/mprr_route_table.sv =====
// routing tables: per-node next hop and per-source advert counts
module mprr_route_table
    import mprr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_own_address,
    input  t_tbl_ctl   i_ctl
);

    logic [7:0]              r_nh_mem  [TABLE_DEPTH];
    logic [7:0]              r_cnt_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  r_cnt_vld;
    logic [7:0]              r_cnt_rd;
    logic                    r_cnt_rd_vld;
    logic [ROUTED_NODES-1:0] r_self;
    logic [ROUTED_NODES-1:0] n_self;
    logic                    r_pend_valid;
    logic [TBL_AW-1:0]       r_pend_addr;
    logic [7:0]              r_pend_data;

    logic [NODE_W-1:0] node;
    logic [TBL_AW-1:0] src_addr;
    logic              src_in_range;
    logic              self_hit;
    logic              node_ok;
    logic              src_wr;

    assign node         = NODE_W'(i_ctl.pay_idx) + NODE_W'(1);
    assign src_addr     = TBL_AW'(i_ctl.src);
    assign src_in_range = {1'b0, i_ctl.src} < 9'(TABLE_DEPTH);
    assign src_wr       = i_ctl.pay_adv && i_ctl.first_pay && src_in_range;

    // r_self mirrors next_hop[i+1] == i+1 for the routed nodes
    always_comb begin
        self_hit = 1'b0;
        for (int i = 0; i < ROUTED_NODES; i++) begin
            if (i_ctl.pay_idx == K_W'(i)) begin
                self_hit = self_hit | r_self[i];
            end
        end
    end

    assign node_ok = (node <= NODE_W'(ROUTED_NODES)) && (9'(node) < 9'(TABLE_DEPTH))
                   && (8'(node) != i_own_address) && (8'(node) != i_ctl.src)
                   && !self_hit && i_ctl.byte_nz;

    // self-route flags follow every table write
    always_comb begin
        n_self = r_self;
        if (src_wr) begin
            for (int i = 0; i < ROUTED_NODES; i++) begin
                if (i_ctl.src == 8'(i + 1)) begin
                    n_self[i] = 1'b1;
                end
            end
        end
        if (i_ctl.pay_adv && node_ok) begin
            for (int i = 0; i < ROUTED_NODES; i++) begin
                if (i_ctl.pay_idx == K_W'(i)) begin
                    n_self[i] = 1'b0;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self       <= '0;
            r_pend_valid <= 1'b0;
            r_cnt_vld    <= '0;
            r_cnt_rd_vld <= 1'b0;
        end else begin
            r_self       <= n_self;
            r_pend_valid <= i_ctl.pay_adv && node_ok;
            r_cnt_rd_vld <= r_cnt_vld[src_addr];
            if (i_ctl.cnt_inc && src_in_range) begin
                r_cnt_vld[src_addr] <= 1'b1;
            end
        end
    end

    // node updates go out through the pending registers so the source write keeps the port
    always_ff @(posedge i_clk) begin
        r_pend_addr <= TBL_AW'(node);
        r_pend_data <= i_ctl.src;
    end

    // next-hop memory, one write port
    always_ff @(posedge i_clk) begin
        if (src_wr) begin
            r_nh_mem[src_addr] <= i_ctl.src;
        end else if (r_pend_valid) begin
            r_nh_mem[r_pend_addr] <= r_pend_data;
        end
    end

    // advert count memory, read each cycle at the source, bumped on the checksum beat
    always_ff @(posedge i_clk) begin
        r_cnt_rd <= r_cnt_mem[src_addr];
        if (i_ctl.cnt_inc && src_in_range) begin
            r_cnt_mem[src_addr] <= (r_cnt_rd_vld ? r_cnt_rd : 8'd0) + 8'd1;
        end
    end

endmodule

// ===== src/mprr_checker.sv =====
// port-level checker for the mesh packet receive router and its bind
module mprr_checker
    import mprr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input t_in_beat   i_in_data,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_beat  o_out_data,
    input logic       i_cfg_we,
    input logic [1:0] i_cfg_idx,
    input logic [7:0] i_cfg_wdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // nothing pending out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input side never blocks while the result side can drain
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled with room in the result register");

    // a fresh result follows an accepted byte
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without an accepted byte");

endmodule

bind mesh_packet_receive_router mprr_checker u_mprr_checker (.*);
